@@ src/gwsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: shared package
// Field widths, cell and scratch entry layouts, terrain costs, controller
// states and the command and status words between controller and datapath.
// ---------------------------------------------------------------------------
package gwsp_pkg;

   localparam int GridRowsDefault = 16;
   localparam int GridColsDefault = 16;

   localparam int CoordW   = 4;
   localparam int TerrainW = 3;
   localparam int OwnerW   = 4;
   localparam int AllowW   = 6;
   localparam int CostW    = 20;
   localparam int StepW    = 11;

   localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

   localparam logic [TerrainW-1:0] TerrGrass    = 3'd0;
   localparam logic [TerrainW-1:0] TerrForest   = 3'd1;
   localparam logic [TerrainW-1:0] TerrRiver    = 3'd2;
   localparam logic [TerrainW-1:0] TerrOcean    = 3'd3;
   localparam logic [TerrainW-1:0] TerrMountain = 3'd4;

   typedef struct packed {
      logic [TerrainW-1:0] terrain;
      logic                walkable;
      logic [OwnerW-1:0]   owner;
      logic [AllowW-1:0]   allowance;
      logic                may_move;
   } cell_type;

   typedef struct packed {
      logic [CostW-1:0] total;
      logic             known;
      logic             settled;
   } dist_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORG_RD,
      ST_DST_RD,
      ST_CHECK,
      ST_CLEAR,
      ST_SEED,
      ST_SCAN,
      ST_SCAN_END,
      ST_PICK,
      ST_SETTLE,
      ST_NB_RD,
      ST_NB_WR,
      ST_DONE
   } gwsp_state_type;

   typedef enum logic [1:0] {
      SEL_ORIGIN,
      SEL_DEST,
      SEL_NEIGHBOUR
   } gwsp_sel_type;

   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } gwsp_dir_type;

   typedef struct packed {
      logic         load_cell;
      logic         capture_query;
      gwsp_sel_type cell_sel;
      logic         latch_origin;
      logic         latch_dest;
      logic         idx_clr;
      logic         idx_inc;
      logic         clear_wr;
      logic         seed_wr;
      logic         scan_issue;
      logic         settle_wr;
      logic         nb_clr;
      logic         nb_inc;
      logic         relax_wr;
      logic         set_reach;
      logic         cost_from_best;
      logic         out_load;
   } gwsp_cmd_type;

   typedef struct packed {
      logic oob;
      logic same_cell;
      logic mover_zero;
      logic idx_last;
      logic found;
      logic best_is_dest;
      logic nb_exists;
      logic nb_last;
      logic out_free;
   } gwsp_status_type;

   // half-steps to enter a cell; zero marks a code that can never be entered
   function automatic logic [StepW-1:0] enter_cost(input logic [TerrainW-1:0] terrain);
      logic [StepW-1:0] cost;
      case (terrain)
         TerrGrass:    cost = 11'd2;
         TerrForest:   cost = 11'd3;
         TerrRiver:    cost = 11'd5;
         TerrOcean:    cost = 11'd1998;
         TerrMountain: cost = 11'd4;
         default:      cost = 11'd0;
      endcase
      return cost;
   endfunction

endpackage

@@ src/gwsp_req_if.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: request channel
// Valid/ready channel carrying one cell load or one query word.
// ---------------------------------------------------------------------------
interface gwsp_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [gwsp_pkg::CoordW-1:0]   row;
   logic [gwsp_pkg::CoordW-1:0]   col;
   logic [gwsp_pkg::TerrainW-1:0] terrain;
   logic                          walkable;
   logic [gwsp_pkg::OwnerW-1:0]   owner;
   logic [gwsp_pkg::AllowW-1:0]   allowance;
   logic                          may_move;
   logic [gwsp_pkg::CoordW-1:0]   dest_row;
   logic [gwsp_pkg::CoordW-1:0]   dest_col;

   modport source (output valid, mode, row, col, terrain, walkable, owner, allowance,
                   may_move, dest_row, dest_col, input ready);
   modport sink   (input valid, mode, row, col, terrain, walkable, owner, allowance,
                   may_move, dest_row, dest_col, output ready);
endinterface

@@ src/gwsp_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: response channel
// Valid/ready channel carrying one query result word.
// ---------------------------------------------------------------------------
interface gwsp_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gwsp_pkg::CostW-1:0] path_cost;
   logic                       reachable;
   logic                       move_allowed;

   modport source (output valid, path_cost, reachable, move_allowed, input ready);
   modport sink   (input valid, path_cost, reachable, move_allowed, output ready);
endinterface

@@ src/gwsp_ram.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module gwsp_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/gwsp_ctrl.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: controller
// Sequences cell loads, query checks, scratch clearing, the minimum scan,
// settling and neighbour relaxation, and hands the result to the output.
// ---------------------------------------------------------------------------
module gwsp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_mode,
   output logic                      req_ready,
   input  gwsp_pkg::gwsp_status_type status,
   output gwsp_pkg::gwsp_cmd_type    cmd
);

   gwsp_pkg::gwsp_state_type state_ff;
   gwsp_pkg::gwsp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwsp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gwsp_pkg::ST_IDLE: begin
            if (req_valid && req_mode) begin
               state_in = gwsp_pkg::ST_ORG_RD;
            end
         end
         gwsp_pkg::ST_ORG_RD:   state_in = gwsp_pkg::ST_DST_RD;
         gwsp_pkg::ST_DST_RD:   state_in = gwsp_pkg::ST_CHECK;
         gwsp_pkg::ST_CHECK: begin
            if (status.oob || status.same_cell || status.mover_zero) begin
               state_in = gwsp_pkg::ST_DONE;
            end else begin
               state_in = gwsp_pkg::ST_CLEAR;
            end
         end
         gwsp_pkg::ST_CLEAR: begin
            if (status.idx_last) begin
               state_in = gwsp_pkg::ST_SEED;
            end
         end
         gwsp_pkg::ST_SEED:     state_in = gwsp_pkg::ST_SCAN;
         gwsp_pkg::ST_SCAN: begin
            if (status.idx_last) begin
               state_in = gwsp_pkg::ST_SCAN_END;
            end
         end
         gwsp_pkg::ST_SCAN_END: state_in = gwsp_pkg::ST_PICK;
         gwsp_pkg::ST_PICK: begin
            if (status.found) begin
               state_in = gwsp_pkg::ST_SETTLE;
            end else begin
               state_in = gwsp_pkg::ST_DONE;
            end
         end
         gwsp_pkg::ST_SETTLE: begin
            if (status.best_is_dest) begin
               state_in = gwsp_pkg::ST_DONE;
            end else begin
               state_in = gwsp_pkg::ST_NB_RD;
            end
         end
         gwsp_pkg::ST_NB_RD: begin
            if (status.nb_exists) begin
               state_in = gwsp_pkg::ST_NB_WR;
            end else if (status.nb_last) begin
               state_in = gwsp_pkg::ST_SCAN;
            end
         end
         gwsp_pkg::ST_NB_WR: begin
            if (status.nb_last) begin
               state_in = gwsp_pkg::ST_SCAN;
            end else begin
               state_in = gwsp_pkg::ST_NB_RD;
            end
         end
         gwsp_pkg::ST_DONE: begin
            if (status.out_free) begin
               state_in = gwsp_pkg::ST_IDLE;
            end
         end
         default:               state_in = gwsp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.cell_sel = gwsp_pkg::SEL_ORIGIN;
      req_ready = 1'b0;
      case (state_ff)
         gwsp_pkg::ST_IDLE: begin
            req_ready         = 1'b1;
            cmd.load_cell     = req_valid && !req_mode;
            cmd.capture_query = req_valid && req_mode;
            cmd.idx_clr       = req_valid && req_mode;
         end
         gwsp_pkg::ST_ORG_RD: begin
            cmd.cell_sel = gwsp_pkg::SEL_ORIGIN;
         end
         gwsp_pkg::ST_DST_RD: begin
            cmd.cell_sel     = gwsp_pkg::SEL_DEST;
            cmd.latch_origin = 1'b1;
         end
         gwsp_pkg::ST_CHECK: begin
            cmd.latch_dest = 1'b1;
            cmd.set_reach  = !status.oob && status.same_cell;
         end
         gwsp_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.idx_inc  = 1'b1;
         end
         gwsp_pkg::ST_SEED: begin
            cmd.seed_wr = 1'b1;
            cmd.idx_clr = 1'b1;
         end
         gwsp_pkg::ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            cmd.idx_inc    = 1'b1;
         end
         gwsp_pkg::ST_SETTLE: begin
            cmd.settle_wr      = 1'b1;
            cmd.set_reach      = status.best_is_dest;
            cmd.cost_from_best = status.best_is_dest;
            cmd.nb_clr         = !status.best_is_dest;
         end
         gwsp_pkg::ST_NB_RD: begin
            cmd.cell_sel = gwsp_pkg::SEL_NEIGHBOUR;
            cmd.nb_inc   = !status.nb_exists;
            cmd.idx_clr  = !status.nb_exists && status.nb_last;
         end
         gwsp_pkg::ST_NB_WR: begin
            cmd.relax_wr = 1'b1;
            cmd.nb_inc   = 1'b1;
            cmd.idx_clr  = status.nb_last;
         end
         gwsp_pkg::ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ src/gwsp_dp.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path: datapath
// Cell store, per-query distance scratch, scan and relaxation arithmetic,
// query registers and the result output register.
// ---------------------------------------------------------------------------
module gwsp_dp #(
   parameter int GRID_ROWS = gwsp_pkg::GridRowsDefault,
   parameter int GRID_COLS = gwsp_pkg::GridColsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gwsp_pkg::gwsp_cmd_type        cmd,
   output gwsp_pkg::gwsp_status_type     status,
   input  logic [gwsp_pkg::CoordW-1:0]   req_row,
   input  logic [gwsp_pkg::CoordW-1:0]   req_col,
   input  logic [gwsp_pkg::TerrainW-1:0] req_terrain,
   input  logic                          req_walkable,
   input  logic [gwsp_pkg::OwnerW-1:0]   req_owner,
   input  logic [gwsp_pkg::AllowW-1:0]   req_allowance,
   input  logic                          req_may_move,
   input  logic [gwsp_pkg::CoordW-1:0]   req_dest_row,
   input  logic [gwsp_pkg::CoordW-1:0]   req_dest_col,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [gwsp_pkg::CostW-1:0]    rsp_path_cost,
   output logic                          rsp_reachable,
   output logic                          rsp_move_allowed
);

   localparam int NumCells = GRID_ROWS * GRID_COLS;
   localparam int CellW    = $clog2(NumCells);
   localparam int RowW     = $clog2(GRID_ROWS);
   localparam int ColW     = $clog2(GRID_COLS);
   localparam int CostW    = gwsp_pkg::CostW;
   localparam logic [CostW-1:0] MoveCap = CostW'(2 * (2 ** gwsp_pkg::AllowW - 1));

   gwsp_pkg::cell_type cell_wdata;
   gwsp_pkg::cell_type cell_rd;
   gwsp_pkg::dist_type dist_wdata;
   gwsp_pkg::dist_type dist_rd;

   logic             cell_we;
   logic [CellW-1:0] cell_raddr;
   logic             dist_we;
   logic [CellW-1:0] dist_waddr;
   logic [CellW-1:0] dist_raddr;

   logic             org_in_grid;
   logic             dst_in_grid;
   logic [CellW-1:0] org_idx;
   logic [CellW-1:0] dst_idx;

   logic [CellW-1:0]           orig_idx_ff;
   logic [CellW-1:0]           dest_idx_ff;
   logic                       oob_ff;
   logic [gwsp_pkg::OwnerW-1:0] mover_ff;
   logic [gwsp_pkg::AllowW-1:0] allow_ff;
   logic                       may_ff;
   logic                       dest_walk_ff;
   logic [gwsp_pkg::OwnerW-1:0] dest_owner_ff;
   logic                       reach_ff;
   logic [CostW-1:0]           cost_ff;

   logic [CellW-1:0] idx_ff;
   logic [RowW-1:0]  scan_row_ff;
   logic [ColW-1:0]  scan_col_ff;
   logic             pipe_vld_ff;
   logic [CellW-1:0] pipe_idx_ff;
   logic [RowW-1:0]  pipe_row_ff;
   logic [ColW-1:0]  pipe_col_ff;

   logic             found_ff;
   logic [CellW-1:0] best_idx_ff;
   logic [RowW-1:0]  best_row_ff;
   logic [ColW-1:0]  best_col_ff;
   logic [CostW-1:0] best_dist_ff;
   logic             take;

   gwsp_pkg::gwsp_dir_type nb_ff;
   logic [CellW-1:0] nb_idx;
   logic             nb_exists;

   logic [gwsp_pkg::StepW-1:0] step;
   logic             enter;
   logic             improve;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CostW-1:0] out_cost_ff;
   logic             out_reach_ff;
   logic             out_move_ff;
   logic             move_ok;
   logic             out_free;

   assign org_in_grid = (int'(req_row) < GRID_ROWS) && (int'(req_col) < GRID_COLS);
   assign dst_in_grid = (int'(req_dest_row) < GRID_ROWS) && (int'(req_dest_col) < GRID_COLS);
   assign org_idx = CellW'(req_row) * CellW'(GRID_COLS) + CellW'(req_col);
   assign dst_idx = CellW'(req_dest_row) * CellW'(GRID_COLS) + CellW'(req_dest_col);

   always_comb begin
      cell_wdata.terrain   = req_terrain;
      cell_wdata.walkable  = req_walkable;
      cell_wdata.owner     = req_owner;
      cell_wdata.allowance = req_allowance;
      cell_wdata.may_move  = req_may_move;
   end

   assign cell_we = cmd.load_cell && org_in_grid;

   always_comb begin
      case (cmd.cell_sel)
         gwsp_pkg::SEL_ORIGIN:    cell_raddr = orig_idx_ff;
         gwsp_pkg::SEL_DEST:      cell_raddr = dest_idx_ff;
         gwsp_pkg::SEL_NEIGHBOUR: cell_raddr = nb_idx;
         default:                 cell_raddr = orig_idx_ff;
      endcase
   end

   gwsp_ram #(
      .Width ($bits(gwsp_pkg::cell_type)),
      .Depth (NumCells)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (org_idx),
      .wdata (cell_wdata),
      .raddr (cell_raddr),
      .rdata (cell_rd)
   );

   always_comb begin
      case (nb_ff)
         gwsp_pkg::DIR_UP: begin
            nb_idx    = best_idx_ff - CellW'(GRID_COLS);
            nb_exists = best_row_ff != '0;
         end
         gwsp_pkg::DIR_DOWN: begin
            nb_idx    = best_idx_ff + CellW'(GRID_COLS);
            nb_exists = best_row_ff != RowW'(GRID_ROWS - 1);
         end
         gwsp_pkg::DIR_LEFT: begin
            nb_idx    = best_idx_ff - CellW'(1);
            nb_exists = best_col_ff != '0;
         end
         gwsp_pkg::DIR_RIGHT: begin
            nb_idx    = best_idx_ff + CellW'(1);
            nb_exists = best_col_ff != ColW'(GRID_COLS - 1);
         end
         default: begin
            nb_idx    = best_idx_ff;
            nb_exists = 1'b0;
         end
      endcase
   end

   assign step    = gwsp_pkg::enter_cost(cell_rd.terrain);
   assign enter   = cell_rd.walkable && (step != '0) &&
                    ((nb_idx == dest_idx_ff) || (cell_rd.owner == '0) ||
                     (cell_rd.owner == mover_ff));
   // relax uses the settled cell's distance, held in best_dist_ff
   logic [CostW:0]   rsum;
   logic [CostW-1:0] rsum_sat;
   assign rsum     = {1'b0, best_dist_ff} + (CostW + 1)'(step);
   assign rsum_sat = rsum[CostW] ? gwsp_pkg::CostMax : rsum[CostW-1:0];
   assign improve  = !dist_rd.settled && enter &&
                     (!dist_rd.known || (rsum_sat < dist_rd.total));

   assign dist_raddr = cmd.scan_issue ? idx_ff : nb_idx;
   assign dist_we    = cmd.clear_wr || cmd.seed_wr || cmd.settle_wr ||
                       (cmd.relax_wr && improve);

   always_comb begin
      dist_waddr = nb_idx;
      dist_wdata = '0;
      if (cmd.clear_wr) begin
         dist_waddr = idx_ff;
      end else if (cmd.seed_wr) begin
         dist_waddr       = orig_idx_ff;
         dist_wdata.known = 1'b1;
      end else if (cmd.settle_wr) begin
         dist_waddr         = best_idx_ff;
         dist_wdata.total   = best_dist_ff;
         dist_wdata.known   = 1'b1;
         dist_wdata.settled = 1'b1;
      end else begin
         dist_wdata.total = rsum_sat;
         dist_wdata.known = 1'b1;
      end
   end

   gwsp_ram #(
      .Width ($bits(gwsp_pkg::dist_type)),
      .Depth (NumCells)
   ) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .raddr (dist_raddr),
      .rdata (dist_rd)
   );

   assign take = pipe_vld_ff && dist_rd.known && !dist_rd.settled &&
                 (!found_ff || (dist_rd.total < best_dist_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture_query) begin
         orig_idx_ff <= org_idx;
         dest_idx_ff <= dst_idx;
         oob_ff      <= !(org_in_grid && dst_in_grid);
      end
      if (cmd.latch_origin) begin
         mover_ff <= cell_rd.owner;
         allow_ff <= cell_rd.allowance;
         may_ff   <= cell_rd.may_move;
      end
      if (cmd.latch_dest) begin
         dest_walk_ff  <= cell_rd.walkable;
         dest_owner_ff <= cell_rd.owner;
      end
      if (cmd.capture_query) begin
         reach_ff <= 1'b0;
         cost_ff  <= '0;
      end else if (cmd.set_reach) begin
         reach_ff <= 1'b1;
         cost_ff  <= cmd.cost_from_best ? best_dist_ff : '0;
      end
      if (cmd.idx_clr) begin
         idx_ff      <= '0;
         scan_row_ff <= '0;
         scan_col_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CellW'(1);
         if (scan_col_ff == ColW'(GRID_COLS - 1)) begin
            scan_col_ff <= '0;
            scan_row_ff <= scan_row_ff + RowW'(1);
         end else begin
            scan_col_ff <= scan_col_ff + ColW'(1);
         end
      end
      pipe_idx_ff <= idx_ff;
      pipe_row_ff <= scan_row_ff;
      pipe_col_ff <= scan_col_ff;
      if (take) begin
         best_idx_ff  <= pipe_idx_ff;
         best_row_ff  <= pipe_row_ff;
         best_col_ff  <= pipe_col_ff;
         best_dist_ff <= dist_rd.total;
      end
      if (cmd.nb_clr) begin
         nb_ff <= gwsp_pkg::DIR_UP;
      end else if (cmd.nb_inc) begin
         nb_ff <= gwsp_pkg::gwsp_dir_type'(nb_ff + 2'd1);
      end
      if (cmd.out_load) begin
         out_cost_ff  <= cost_ff;
         out_reach_ff <= reach_ff;
         out_move_ff  <= move_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pipe_vld_ff  <= cmd.scan_issue;
         if (cmd.idx_clr) begin
            found_ff <= 1'b0;
         end else if (take) begin
            found_ff <= 1'b1;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign move_ok = dest_walk_ff && (dest_owner_ff == '0) && (mover_ff != '0) && may_ff &&
                    reach_ff && (cost_ff <= CostW'({allow_ff, 1'b0}));

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      status.oob          = oob_ff;
      status.same_cell    = orig_idx_ff == dest_idx_ff;
      status.mover_zero   = mover_ff == '0;
      status.idx_last     = idx_ff == CellW'(NumCells - 1);
      status.found        = found_ff;
      status.best_is_dest = best_idx_ff == dest_idx_ff;
      status.nb_exists    = nb_exists;
      status.nb_last      = nb_ff == gwsp_pkg::DIR_RIGHT;
      status.out_free     = out_free;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_path_cost    = out_cost_ff;
   assign rsp_reachable    = out_reach_ff;
   assign rsp_move_allowed = out_move_ff;

   a_settle_found: assert property (@(posedge clock) disable iff (reset)
      cmd.settle_wr |-> found_ff)
      else $error("settle without a chosen cell");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> out_free)
      else $error("result loaded over a waiting word");

   a_move_reach: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_move_ff) |-> (out_reach_ff && (out_cost_ff <= MoveCap)))
      else $error("move allowed on unreachable or too costly path");

endmodule

@@ src/grid_weighted_shortest_path_unit.sv @@
// ---------------------------------------------------------------------------
// Grid weighted shortest path unit
// Cell loads are accepted back to back while the unit is idle. A query runs
// the origin and destination reads and checks, which may end it early,
// then a clearing pass over the distance scratch of GRID_ROWS*GRID_COLS
// entries, then for every settled cell a full scan of the scratch memory
// and the settling and neighbour relaxation. The single read port of the
// scratch memory is swept once per settled cell. The result word is held
// in an output register while new cell loads go on.
// ---------------------------------------------------------------------------
module grid_weighted_shortest_path_unit #(
   parameter int GRID_ROWS = gwsp_pkg::GridRowsDefault,
   parameter int GRID_COLS = gwsp_pkg::GridColsDefault
) (
   input logic        clock,
   input logic        reset,
   gwsp_req_if.sink   req_chan,
   gwsp_rsp_if.source rsp_chan
);

   gwsp_pkg::gwsp_cmd_type    cmd;
   gwsp_pkg::gwsp_status_type status;

   gwsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_mode  (req_chan.mode),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   gwsp_dp #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_row          (req_chan.row),
      .req_col          (req_chan.col),
      .req_terrain      (req_chan.terrain),
      .req_walkable     (req_chan.walkable),
      .req_owner        (req_chan.owner),
      .req_allowance    (req_chan.allowance),
      .req_may_move     (req_chan.may_move),
      .req_dest_row     (req_chan.dest_row),
      .req_dest_col     (req_chan.dest_col),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_path_cost    (rsp_chan.path_cost),
      .rsp_reachable    (rsp_chan.reachable),
      .rsp_move_allowed (rsp_chan.move_allowed)
   );

endmodule
